FILE: rtl/core/kbdsc_pkg.sv
// ============================================================================
// kbdsc_pkg
// Shared types, key codes and the US-layout scan code table for the
// set-1 scan code line decoder.
// ============================================================================
package kbdsc_pkg;

  // Line store depth; the fill counter must be able to hold the depth itself
  localparam int unsigned LineDepth = 128;
  localparam int unsigned CntW      = $clog2(LineDepth + 1);

  // Event kinds on the result channel
  typedef enum logic [2:0] {
    KIND_CHAR      = 3'd0,
    KIND_LINE_END  = 3'd1,
    KIND_BACKSPACE = 3'd2,
    KIND_CUR_LEFT  = 3'd3,
    KIND_CUR_RIGHT = 3'd4
  } kind_e;

  // Key codes with special handling
  localparam logic [6:0] KeyEsc       = 7'h01;
  localparam logic [6:0] KeyBackspace = 7'h0E;
  localparam logic [6:0] KeyEnter     = 7'h1C;
  localparam logic [6:0] KeyCtrl      = 7'h1D;
  localparam logic [6:0] KeyLShift    = 7'h2A;
  localparam logic [6:0] KeyRShift    = 7'h36;
  localparam logic [6:0] KeyAlt       = 7'h38;
  localparam logic [6:0] KeyCaps      = 7'h3A;
  localparam logic [6:0] KeyF1        = 7'h3B;
  localparam logic [6:0] KeyF2        = 7'h3C;
  localparam logic [6:0] KeyF3        = 7'h3D;
  localparam logic [6:0] KeyF4        = 7'h3E;
  localparam logic [6:0] KeyF5        = 7'h3F;
  localparam logic [6:0] KeyF6        = 7'h40;
  localparam logic [6:0] KeyF7        = 7'h41;
  localparam logic [6:0] KeyF8        = 7'h42;
  localparam logic [6:0] KeyF9        = 7'h43;
  localparam logic [6:0] KeyF10       = 7'h44;
  localparam logic [6:0] KeyUp        = 7'h48;
  localparam logic [6:0] KeyLeft      = 7'h4B;
  localparam logic [6:0] KeyRight     = 7'h4D;
  localparam logic [6:0] KeyDown      = 7'h50;
  localparam logic [6:0] KeyDelete    = 7'h53;
  localparam logic [6:0] KeyF11       = 7'h57;
  localparam logic [6:0] KeyF12       = 7'h58;
  localparam logic [6:0] KeyPrefix    = 7'h60;

  localparam logic [7:0] CharNewline  = 8'h0A;
  localparam logic [7:0] CharUnknown  = 8'hFF;

  // One decoded event
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  char_code;
    logic [7:0]  line_pos;
    logic        overflow;
  } evt_t;

  // US-layout glyph lookup; upper selects the shifted glyph
  function automatic logic [7:0] key_char(input logic [6:0] code, input logic upper);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = {1'b0, code};
    hi = {1'b0, code};
    case (code)
      7'h00: begin lo = CharUnknown; hi = CharUnknown; end
      7'h02: begin lo = 8'h31; hi = 8'h21; end
      7'h03: begin lo = 8'h32; hi = 8'h40; end
      7'h04: begin lo = 8'h33; hi = 8'h23; end
      7'h05: begin lo = 8'h34; hi = 8'h24; end
      7'h06: begin lo = 8'h35; hi = 8'h25; end
      7'h07: begin lo = 8'h36; hi = 8'h5E; end
      7'h08: begin lo = 8'h37; hi = 8'h26; end
      7'h09: begin lo = 8'h38; hi = 8'h2A; end
      7'h0A: begin lo = 8'h39; hi = 8'h28; end
      7'h0B: begin lo = 8'h30; hi = 8'h29; end
      7'h0C: begin lo = 8'h2D; hi = 8'h5F; end
      7'h0D: begin lo = 8'h3D; hi = 8'h2B; end
      7'h0E: begin lo = 8'h08; hi = 8'h08; end
      7'h0F: begin lo = 8'h09; hi = 8'h09; end
      7'h10: begin lo = 8'h71; hi = 8'h51; end
      7'h11: begin lo = 8'h77; hi = 8'h57; end
      7'h12: begin lo = 8'h65; hi = 8'h45; end
      7'h13: begin lo = 8'h72; hi = 8'h52; end
      7'h14: begin lo = 8'h74; hi = 8'h54; end
      7'h15: begin lo = 8'h79; hi = 8'h59; end
      7'h16: begin lo = 8'h75; hi = 8'h55; end
      7'h17: begin lo = 8'h69; hi = 8'h49; end
      7'h18: begin lo = 8'h6F; hi = 8'h4F; end
      7'h19: begin lo = 8'h70; hi = 8'h50; end
      7'h1A: begin lo = 8'h5B; hi = 8'h7B; end
      7'h1B: begin lo = 8'h5D; hi = 8'h7D; end
      7'h1C: begin lo = 8'h0A; hi = 8'h0A; end
      7'h1E: begin lo = 8'h61; hi = 8'h41; end
      7'h1F: begin lo = 8'h73; hi = 8'h53; end
      7'h20: begin lo = 8'h64; hi = 8'h44; end
      7'h21: begin lo = 8'h66; hi = 8'h46; end
      7'h22: begin lo = 8'h67; hi = 8'h47; end
      7'h23: begin lo = 8'h68; hi = 8'h48; end
      7'h24: begin lo = 8'h6A; hi = 8'h4A; end
      7'h25: begin lo = 8'h6B; hi = 8'h4B; end
      7'h26: begin lo = 8'h6C; hi = 8'h4C; end
      7'h27: begin lo = 8'h3B; hi = 8'h3A; end
      7'h28: begin lo = 8'h27; hi = 8'h22; end
      7'h29: begin lo = 8'h60; hi = 8'h7E; end
      7'h2B: begin lo = 8'h5C; hi = 8'h7C; end
      7'h2C: begin lo = 8'h7A; hi = 8'h5A; end
      7'h2D: begin lo = 8'h78; hi = 8'h58; end
      7'h2E: begin lo = 8'h63; hi = 8'h43; end
      7'h2F: begin lo = 8'h76; hi = 8'h56; end
      7'h30: begin lo = 8'h62; hi = 8'h42; end
      7'h31: begin lo = 8'h6E; hi = 8'h4E; end
      7'h32: begin lo = 8'h6D; hi = 8'h4D; end
      7'h33: begin lo = 8'h2C; hi = 8'h3C; end
      7'h34: begin lo = 8'h2E; hi = 8'h3E; end
      7'h35: begin lo = 8'h2F; hi = 8'h3F; end
      7'h37: begin lo = 8'h2A; hi = 8'h2A; end
      7'h39: begin lo = 8'h20; hi = 8'h20; end
      7'h4A: begin lo = 8'h2D; hi = 8'h2D; end
      7'h4C: begin lo = CharUnknown; hi = CharUnknown; end
      7'h4E: begin lo = 8'h2B; hi = 8'h2B; end
      7'h54, 7'h55, 7'h56: begin lo = CharUnknown; hi = CharUnknown; end
      default: begin
        // codes past the table are unknown; the rest map to themselves
        if (code >= 7'h59) begin
          lo = CharUnknown;
          hi = CharUnknown;
        end
      end
    endcase
    return upper ? hi : lo;
  endfunction

endpackage

FILE: rtl/core/kbdsc_if.sv
// ============================================================================
// kbdsc_scan_if / kbdsc_event_if
// Valid/ready channels for raw scan bytes and decoded line events.
// ============================================================================
interface kbdsc_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface kbdsc_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] char_code;
  logic [7:0] line_pos;
  logic       line_overflow;

  modport source (output valid, output event_kind, output char_code,
                  output line_pos, output line_overflow, input ready);
  modport sink   (input valid, input event_kind, input char_code,
                  input line_pos, input line_overflow, output ready);
endinterface

FILE: rtl/core/kbdsc_line_ctrl.sv
// ============================================================================
// kbdsc_line_ctrl
// Keeps shift, caps and line position; classifies one scan byte per cycle
// in which fire_i accepts it and produces at most one event.
// ============================================================================
module kbdsc_line_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       scan_byte_i,
  output logic             evt_valid_o,
  output kbdsc_pkg::evt_t  evt_o
);

  logic                       shift_q, shift_d;
  logic                       caps_q, caps_d;
  logic [kbdsc_pkg::CntW-1:0] count_q, count_d;

  logic [6:0] code;
  logic       pressed;
  logic       upper;
  logic       full;

  assign code    = scan_byte_i[6:0];
  assign pressed = ~scan_byte_i[7];
  assign full    = (count_q >= kbdsc_pkg::CntW'(kbdsc_pkg::LineDepth));
  // digit row follows shift, everything else follows caps
  assign upper   = (code >= 7'h02 && code <= 7'h0B) ? shift_q : caps_q;

  // Key classification and next state
  always_comb begin
    shift_d         = shift_q;
    caps_d          = caps_q;
    count_d         = count_q;
    evt_valid_o     = 1'b0;
    evt_o.kind      = kbdsc_pkg::KIND_CHAR;
    evt_o.char_code = 8'h00;
    evt_o.line_pos  = 8'(count_q);
    evt_o.overflow  = 1'b0;
    case (code)
      kbdsc_pkg::KeyPrefix, kbdsc_pkg::KeyUp, kbdsc_pkg::KeyDown: begin
      end
      kbdsc_pkg::KeyEsc, kbdsc_pkg::KeyEnter: begin
        if (!pressed) begin
          count_d         = '0;
          evt_valid_o     = 1'b1;
          evt_o.kind      = kbdsc_pkg::KIND_LINE_END;
          evt_o.char_code = kbdsc_pkg::CharNewline;
          evt_o.line_pos  = 8'h00;
        end
      end
      kbdsc_pkg::KeyCtrl, kbdsc_pkg::KeyAlt, kbdsc_pkg::KeyLShift,
      kbdsc_pkg::KeyRShift, kbdsc_pkg::KeyDelete, kbdsc_pkg::KeyF11,
      kbdsc_pkg::KeyF12, kbdsc_pkg::KeyF1, kbdsc_pkg::KeyF2, kbdsc_pkg::KeyF3,
      kbdsc_pkg::KeyF4, kbdsc_pkg::KeyF5, kbdsc_pkg::KeyF6, kbdsc_pkg::KeyF7,
      kbdsc_pkg::KeyF8, kbdsc_pkg::KeyF9, kbdsc_pkg::KeyF10: begin
        shift_d = pressed;
        caps_d  = ~caps_q;
      end
      kbdsc_pkg::KeyCaps: begin
        if (pressed) caps_d = ~caps_q;
      end
      kbdsc_pkg::KeyLeft: begin
        if (pressed) begin
          evt_valid_o = 1'b1;
          evt_o.kind  = kbdsc_pkg::KIND_CUR_LEFT;
        end
      end
      kbdsc_pkg::KeyRight: begin
        if (pressed) begin
          evt_valid_o = 1'b1;
          evt_o.kind  = kbdsc_pkg::KIND_CUR_RIGHT;
        end
      end
      kbdsc_pkg::KeyBackspace: begin
        if (pressed) begin
          // saturate at the start of the line
          if (count_q != '0) count_d = count_q - 1'b1;
          evt_valid_o    = 1'b1;
          evt_o.kind     = kbdsc_pkg::KIND_BACKSPACE;
          evt_o.line_pos = 8'(count_d);
        end
      end
      default: begin
        if (!pressed) begin
          evt_valid_o     = 1'b1;
          evt_o.char_code = kbdsc_pkg::key_char(code, upper);
          evt_o.overflow  = full;
          if (!full) count_d = count_q + 1'b1;
        end
      end
    endcase
  end

  // State registers, updated only on an accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
      count_q <= '0;
    end else if (fire_i) begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/core/keyboard_scancode_line_decoder_top.sv
// ============================================================================
// keyboard_scancode_line_decoder_top
// Set-1 scan bytes in, US-layout line events out.
// ============================================================================
// Usage:
//   scan_i  carries one raw set-1 scan byte per transaction (bit 7 = release).
//   event_o carries at most one event per byte: character, line end,
//           backspace, cursor left or cursor right, with the line position
//           and an overflow flag for characters typed into a full line.
//   Bytes that cause no event (modifiers, caps, prefixes, up/down, presses of
//   character/Esc/Enter keys, releases of other keys) are consumed silently.
// Timing:
//   A byte sits in the input register; its event is decoded from there and
//   captured in the output register. One byte is taken every cycle unless
//   event_o stalls; the decode is a single table lookup and counter step.
// Reset:
//   Shift and caps clear, the line position returns to zero, both stages
//   empty.
// Stall:
//   While event_o is held off the output register keeps its event and the
//   input register holds one more byte; scan_i.ready drops once both full.
// ============================================================================
module keyboard_scancode_line_decoder_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  kbdsc_scan_if.sink           scan_i,
  kbdsc_event_if.source        event_o
);

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            out_valid_q;
  kbdsc_pkg::evt_t out_evt_q;

  logic            out_free;
  logic            fire;
  logic            evt_valid;
  kbdsc_pkg::evt_t evt;

  assign out_free     = ~out_valid_q | event_o.ready;
  assign fire         = in_valid_q & out_free;
  assign scan_i.ready = ~in_valid_q | out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (scan_i.ready) begin
      in_valid_q <= scan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i.ready && scan_i.valid) begin
      in_byte_q <= scan_i.scan_byte;
    end
  end

  kbdsc_line_ctrl u_line_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .scan_byte_i (in_byte_q),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire & evt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && evt_valid) begin
      out_evt_q <= evt;
    end
  end

  assign event_o.valid         = out_valid_q;
  assign event_o.event_kind    = out_evt_q.kind;
  assign event_o.char_code     = out_evt_q.char_code;
  assign event_o.line_pos      = out_evt_q.line_pos;
  assign event_o.line_overflow = out_evt_q.overflow;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the set-1 scan code line decoder. Scan bytes are
// pushed through a bursty valid/ready source, every accepted byte is run
// through a local decoder that tracks shift, caps and the line fill, and
// each event taken off the throttled result channel is compared field by
// field with the oldest predicted event.
// ============================================================================
module tb;

  localparam int         DrainCycles = 16;
  localparam logic [6:0] DigitFirst  = 7'h02;
  localparam logic [6:0] DigitLast   = 7'h0B;

  // Glyph rows of the US layout, left to right
  localparam logic [95:0] RowNumLo = "1234567890-=";
  localparam logic [95:0] RowNumHi = "!@#$%^&*()_+";
  localparam logic [95:0] RowTopLo = "qwertyuiop[]";
  localparam logic [95:0] RowTopHi = "QWERTYUIOP{}";
  localparam logic [95:0] RowMidLo = "asdfghjkl;";
  localparam logic [95:0] RowMidHi = "ASDFGHJKL:";
  localparam logic [95:0] RowBotLo = "zxcvbnm,./";
  localparam logic [95:0] RowBotHi = "ZXCVBNM<>?";

  logic clk_i = 1'b0;
  logic rst_ni;

  kbdsc_scan_if  scan_ch ();
  kbdsc_event_if evt_ch ();

  keyboard_scancode_line_decoder_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scan_i  (scan_ch),
    .event_o (evt_ch)
  );

  // Decoder state as the block should hold it
  logic            shift_held = 1'b0;
  logic            caps_on    = 1'b0;
  logic [15:0]     line_fill  = '0;
  kbdsc_pkg::evt_t pending_events[$];

  int mismatch_cnt = 0;
  int burst_left   = 0;
  int rx_stall_max = 6;
  bit tx_throttle  = 1'b0;
  bit rx_throttle  = 1'b0;

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Local decoder
  // ---------------------------------------------------------------------------

  function automatic logic is_modifier(input logic [6:0] code);
    return (code == kbdsc_pkg::KeyCtrl) || (code == kbdsc_pkg::KeyAlt) ||
           (code == kbdsc_pkg::KeyLShift) || (code == kbdsc_pkg::KeyRShift) ||
           (code == kbdsc_pkg::KeyDelete) || (code == kbdsc_pkg::KeyF11) ||
           (code == kbdsc_pkg::KeyF12) ||
           (code >= kbdsc_pkg::KeyF1 && code <= kbdsc_pkg::KeyF10);
  endfunction

  function automatic logic [7:0] row_byte(input logic [95:0] row, input int len,
                                          input int idx);
    return row[8*(len-1-idx) +: 8];
  endfunction

  function automatic logic [7:0] glyph(input logic [6:0] code, input logic upper);
    logic [7:0] g;
    g = {1'b0, code};
    if (code >= 7'h02 && code <= 7'h0D)
      g = row_byte(upper ? RowNumHi : RowNumLo, 12, code - 7'h02);
    else if (code >= 7'h10 && code <= 7'h1B)
      g = row_byte(upper ? RowTopHi : RowTopLo, 12, code - 7'h10);
    else if (code >= 7'h1E && code <= 7'h27)
      g = row_byte(upper ? RowMidHi : RowMidLo, 10, code - 7'h1E);
    else if (code >= 7'h2C && code <= 7'h35)
      g = row_byte(upper ? RowBotHi : RowBotLo, 10, code - 7'h2C);
    else begin
      case (code)
        7'h00, 7'h4C, 7'h54, 7'h55, 7'h56: g = kbdsc_pkg::CharUnknown;
        7'h0E: g = 8'h08;
        7'h0F: g = 8'h09;
        7'h1C: g = kbdsc_pkg::CharNewline;
        7'h28: g = upper ? 8'h22 : 8'h27;
        7'h29: g = upper ? 8'h7E : 8'h60;
        7'h2B: g = upper ? 8'h7C : 8'h5C;
        7'h37: g = 8'h2A;
        7'h39: g = 8'h20;
        7'h4A: g = 8'h2D;
        7'h4E: g = 8'h2B;
        default: begin
          if (code >= 7'h59) g = kbdsc_pkg::CharUnknown;
        end
      endcase
    end
    return g;
  endfunction

  // Update the decoder state for one accepted byte and queue its event
  function automatic void decode_scan(input logic [7:0] scan);
    logic [6:0]      code;
    logic            pressed;
    logic            fire;
    kbdsc_pkg::evt_t e;
    code        = scan[6:0];
    pressed     = !scan[7];
    fire        = 1'b0;
    e.kind      = kbdsc_pkg::KIND_CHAR;
    e.char_code = 8'h00;
    e.line_pos  = 8'h00;
    e.overflow  = 1'b0;
    if (code == kbdsc_pkg::KeyPrefix || code == kbdsc_pkg::KeyUp ||
        code == kbdsc_pkg::KeyDown) begin
      // ignored outright
    end else if (code == kbdsc_pkg::KeyEsc || code == kbdsc_pkg::KeyEnter) begin
      if (!pressed) begin
        line_fill   = '0;
        fire        = 1'b1;
        e.kind      = kbdsc_pkg::KIND_LINE_END;
        e.char_code = kbdsc_pkg::CharNewline;
      end
    end else if (is_modifier(code)) begin
      shift_held = pressed;
      caps_on    = !caps_on;
    end else if (code == kbdsc_pkg::KeyCaps) begin
      if (pressed) caps_on = !caps_on;
    end else if (code == kbdsc_pkg::KeyLeft || code == kbdsc_pkg::KeyRight) begin
      if (pressed) begin
        fire       = 1'b1;
        e.kind     = (code == kbdsc_pkg::KeyLeft) ? kbdsc_pkg::KIND_CUR_LEFT :
                                                    kbdsc_pkg::KIND_CUR_RIGHT;
        e.line_pos = line_fill[7:0];
      end
    end else if (code == kbdsc_pkg::KeyBackspace) begin
      if (pressed) begin
        if (line_fill != 0) line_fill = line_fill - 1'b1;
        fire       = 1'b1;
        e.kind     = kbdsc_pkg::KIND_BACKSPACE;
        e.line_pos = line_fill[7:0];
      end
    end else if (!pressed) begin
      // digits follow shift, everything else follows caps
      fire        = 1'b1;
      e.char_code = glyph(code, (code >= DigitFirst && code <= DigitLast) ?
                                shift_held : caps_on);
      if (line_fill >= kbdsc_pkg::LineDepth) begin
        line_fill  = 16'(kbdsc_pkg::LineDepth);
        e.line_pos = line_fill[7:0];
        e.overflow = 1'b1;
      end else begin
        e.line_pos = line_fill[7:0];
        line_fill  = line_fill + 1'b1;
      end
    end
    if (fire) pending_events.push_back(e);
  endfunction

  // ---------------------------------------------------------------------------
  // Scan byte source
  // ---------------------------------------------------------------------------

  // One transaction on scan_i; valid stays up for a following byte
  task automatic send_scan(input logic [7:0] scan);
    int gap;
    if (tx_throttle) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          scan_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    scan_ch.valid     <= 1'b1;
    scan_ch.scan_byte <= scan;
    do @(posedge clk_i); while (!scan_ch.ready);
    decode_scan(scan);
  endtask

  task automatic key_stroke(input logic [6:0] code);
    send_scan({1'b0, code});
    send_scan({1'b1, code});
  endtask

  // A key that decodes to a character, now and then one from the unknown range
  function automatic logic [6:0] random_char_key();
    logic [6:0] k;
    int         r;
    do begin
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 88);
      k = r[6:0];
    end while (is_modifier(k) || k == kbdsc_pkg::KeyPrefix || k == kbdsc_pkg::KeyUp ||
               k == kbdsc_pkg::KeyDown || k == kbdsc_pkg::KeyEsc ||
               k == kbdsc_pkg::KeyEnter || k == kbdsc_pkg::KeyCaps ||
               k == kbdsc_pkg::KeyLeft || k == kbdsc_pkg::KeyRight ||
               k == kbdsc_pkg::KeyBackspace);
    return k;
  endfunction

  // Mostly well-formed keystrokes, with a little raw noise
  task automatic type_session(input int n_bytes);
    int         sent;
    int         pick;
    int         r;
    logic [6:0] k;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        key_stroke(random_char_key());
        sent += 2;
      end else if (pick < 68) begin
        // modifier held over a few characters
        case ($urandom_range(0, 5))
          0: k = kbdsc_pkg::KeyLShift;
          1: k = kbdsc_pkg::KeyRShift;
          2: k = kbdsc_pkg::KeyCtrl;
          3: k = kbdsc_pkg::KeyAlt;
          4: k = kbdsc_pkg::KeyDelete;
          default: begin
            r = $urandom_range(0, 11);
            k = (r < 10) ? kbdsc_pkg::KeyF1 + r[6:0] :
                ((r == 10) ? kbdsc_pkg::KeyF11 : kbdsc_pkg::KeyF12);
          end
        endcase
        r = $urandom_range(1, 4);
        send_scan({1'b0, k});
        repeat (r) key_stroke(random_char_key());
        send_scan({1'b1, k});
        sent += 2 + 2 * r;
      end else if (pick < 73) begin
        key_stroke(kbdsc_pkg::KeyCaps);
        sent += 2;
      end else if (pick < 80) begin
        key_stroke(kbdsc_pkg::KeyBackspace);
        sent += 2;
      end else if (pick < 85) begin
        key_stroke($urandom_range(0, 1) ? kbdsc_pkg::KeyLeft : kbdsc_pkg::KeyRight);
        sent += 2;
      end else if (pick < 90) begin
        key_stroke($urandom_range(0, 1) ? kbdsc_pkg::KeyEnter : kbdsc_pkg::KeyEsc);
        sent += 2;
      end else if (pick < 94) begin
        // extended key: E0 prefix then an arrow
        send_scan({1'b1, kbdsc_pkg::KeyPrefix});
        case ($urandom_range(0, 3))
          0: key_stroke(kbdsc_pkg::KeyUp);
          1: key_stroke(kbdsc_pkg::KeyDown);
          2: key_stroke(kbdsc_pkg::KeyLeft);
          default: key_stroke(kbdsc_pkg::KeyRight);
        endcase
        sent += 3;
      end else begin
        r = $urandom_range(0, 255);
        send_scan(r[7:0]);
        sent += 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Event sink: always ready, or when throttled alternating open and stalled stretches
  // ---------------------------------------------------------------------------
  initial begin : rx_pace
    int   run_left;
    logic stall_now;
    run_left  = 0;
    stall_now = 1'b0;
    evt_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rx_throttle) begin
        evt_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          stall_now = !stall_now;
          run_left  = stall_now ? $urandom_range(1, rx_stall_max) : $urandom_range(1, 12);
        end
        run_left--;
        evt_ch.ready <= !stall_now;
      end
    end
  end

  // Compare each event transaction with the oldest prediction
  always @(posedge clk_i) begin : event_check
    kbdsc_pkg::evt_t want;
    if (rst_ni && evt_ch.valid && evt_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d char %h pos %0d ovf %b", $time,
                 evt_ch.event_kind, evt_ch.char_code, evt_ch.line_pos,
                 evt_ch.line_overflow);
        mismatch_cnt++;
      end else begin
        want = pending_events.pop_front();
        if (evt_ch.event_kind !== want.kind || evt_ch.char_code !== want.char_code ||
            evt_ch.line_pos !== want.line_pos || evt_ch.line_overflow !== want.overflow) begin
          $display("%0t: event mismatch: expected kind %0d char %h pos %0d ovf %b",
                   $time, want.kind, want.char_code, want.line_pos, want.overflow);
          $display("%0t:                 actual   kind %0d char %h pos %0d ovf %b",
                   $time, evt_ch.event_kind, evt_ch.char_code, evt_ch.line_pos,
                   evt_ch.line_overflow);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every key class at least once, back to back
  task automatic test_directed_keys();
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    send_scan({1'b0, kbdsc_pkg::KeyPrefix});     // masked prefix does nothing
    send_scan({1'b1, kbdsc_pkg::KeyPrefix});
    send_scan({1'b0, kbdsc_pkg::KeyUp});         // up/down never do anything
    send_scan({1'b1, kbdsc_pkg::KeyDown});
    send_scan(8'h1E);                            // letter press: silent
    send_scan(8'h9E);                            // 'a' into slot 0
    send_scan(8'h80);                            // code 0 is unknown
    send_scan(8'hFF);                            // top of the code space
    send_scan(8'hCC);                            // hole in the keypad
    send_scan(8'h8F);                            // tab maps to 0x09
    send_scan({1'b0, kbdsc_pkg::KeyLShift});     // shift on, caps toggles
    send_scan(8'h82);                            // shifted digit
    send_scan(8'h9E);                            // upper case through caps
    send_scan({1'b1, kbdsc_pkg::KeyLShift});
    send_scan({1'b0, kbdsc_pkg::KeyCaps});
    send_scan({1'b1, kbdsc_pkg::KeyCaps});       // caps release is silent
    send_scan(8'h82);                            // digit ignores caps
    send_scan(8'h8C);                            // minus follows caps
    key_stroke(kbdsc_pkg::KeyLeft);
    send_scan({1'b0, kbdsc_pkg::KeyRight});
    key_stroke(kbdsc_pkg::KeyBackspace);
    key_stroke(kbdsc_pkg::KeyEnter);
    send_scan({1'b0, kbdsc_pkg::KeyBackspace});  // at slot 0 the position stays put
    send_scan({1'b1, kbdsc_pkg::KeyEsc});
  endtask

  task automatic test_typing();
    rx_stall_max = 6;
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    type_session(200);
    tx_throttle = 1'b0;
    type_session(100);
    tx_throttle = 1'b1;
    rx_throttle = 1'b0;
    type_session(100);
    tx_throttle = 1'b0;
    type_session(60);
  endtask

  // Fill the line past its depth under long stalls, then back off and end it
  task automatic test_line_overflow();
    logic [6:0] k;
    tx_throttle  = 1'b1;
    rx_throttle  = 1'b1;
    rx_stall_max = 20;
    key_stroke(kbdsc_pkg::KeyEnter);
    repeat (kbdsc_pkg::LineDepth + 6) begin
      k = random_char_key();
      if ($urandom_range(0, 1)) send_scan({1'b0, k});
      send_scan({1'b1, k});
    end
    key_stroke(kbdsc_pkg::KeyBackspace);
    key_stroke(kbdsc_pkg::KeyBackspace);
    repeat (4) send_scan({1'b1, random_char_key()});
    key_stroke(kbdsc_pkg::KeyRight);
    key_stroke(kbdsc_pkg::KeyLeft);
    key_stroke(kbdsc_pkg::KeyEsc);
  endtask

  task automatic test_raw_bytes();
    int r;
    tx_throttle  = 1'b1;
    rx_throttle  = 1'b1;
    rx_stall_max = 8;
    repeat (150) begin
      r = $urandom_range(0, 255);
      send_scan(r[7:0]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    scan_ch.valid     = 1'b0;
    scan_ch.scan_byte = 8'h00;
    rst_ni            = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    shift_held = 1'b0;
    caps_on    = 1'b0;
    line_fill  = '0;

    test_directed_keys();
    test_typing();
    test_line_overflow();
    test_raw_bytes();

    scan_ch.valid <= 1'b0;
    rx_throttle = 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: keyboard_scancode_line_decoder_top.f
rtl/core/kbdsc_pkg.sv
rtl/core/kbdsc_if.sv
rtl/core/kbdsc_line_ctrl.sv
rtl/core/keyboard_scancode_line_decoder_top.sv
tb/tb.sv
